// File: hdl/mlfd_pkg.sv
// Shared types and constants for the magic/length frame deframer.
package mlfd_pkg;

   localparam int unsigned BYTE_BITS      = 8;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC_WORD = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] MAGIC_WORD_RESET = 32'h0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] MAX_LENGTH_RESET = 32'd1048576;

   // header byte positions
   localparam logic [2:0] HDR_LEN_FIRST = 3'd4;
   localparam logic [2:0] HDR_LAST      = 3'd7;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_of_frame;
      logic                 frame_error;
   } rsp_item_type;

   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } rsp_push_type;

endpackage

// File: hdl/mlfd_if.sv
// Request and response channel interfaces.
interface mlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface mlfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_frame;
   logic       frame_error;

   modport source (output valid, output out_byte, output last_of_frame, output frame_error,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_frame, input frame_error,
                 output ready);
endinterface

// File: hdl/magic_length_frame_deframer_top.sv
// Top level of the magic/length frame deframer.
// Takes one stream byte per request and returns a response for every payload byte (with a
// last-of-frame flag on the final one) and a single frame_error response when an 8-byte header
// carries the wrong magic, a zero length or a length above max_length; after that error all
// further bytes are dropped until reset. One byte is accepted every cycle unless the response
// buffer is full; a request passes the input register and then the two-entry response buffer,
// which holds responses while the response side stalls. LENGTH_BITS sets the width of the
// payload counter; longer lengths are rejected. Registers must be written through
// csr_write_en/csr_index/csr_wdata only while the block is idle; the block does not enforce it.
module magic_length_frame_deframer_top
   import mlfd_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   mlfd_req_if.sink                  req_if,
   mlfd_rsp_if.source                rsp_if
);

   rsp_push_type res;
   logic         res_ready;
   rsp_item_type out_item;

   mlfd_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (req_if.valid),
      .in_byte      (req_if.in_byte),
      .in_ready     (req_if.ready),
      .res_ready    (res_ready),
      .res          (res)
   );

   mlfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .res_ready (res_ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (out_item)
   );

   assign rsp_if.out_byte      = out_item.out_byte;
   assign rsp_if.last_of_frame = out_item.last_of_frame;
   assign rsp_if.frame_error   = out_item.frame_error;

endmodule

// File: hdl/mlfd_core.sv
// Input register, header parser, payload counter and control registers.
module mlfd_core
   import mlfd_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      in_valid,
   input  logic [BYTE_BITS-1:0]      in_byte,
   output logic                      in_ready,
   input  logic                      res_ready,
   output rsp_push_type              res
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   logic [CSR_DATA_BITS-1:0] magic_word_ff, magic_word_in;
   logic [CSR_DATA_BITS-1:0] max_length_ff, max_length_in;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff, in_byte_in;

   phase_type              phase_ff, phase_in;
   logic [2:0]             hdr_count_ff, hdr_count_in;
   logic [31:0]            magic_ff, magic_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   len_ovf_ff, len_ovf_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   logic                             advance;
   logic [LENGTH_BITS-1:0]           len_base;
   logic [LENGTH_BITS+BYTE_BITS-1:0] len_wide;
   logic [LENGTH_BITS-1:0]           len_next;
   logic                             ovf_next;
   logic                             hdr_ok;

   assign advance  = in_valid_ff && res_ready;
   assign in_ready = !in_valid_ff || res_ready;

   assign len_base = (hdr_count_ff == HDR_LEN_FIRST) ? '0 : len_ff;
   assign len_wide = {len_base, in_byte_ff};
   assign len_next = len_wide[LENGTH_BITS-1:0];
   assign ovf_next = ((hdr_count_ff == HDR_LEN_FIRST) ? 1'b0 : len_ovf_ff)
                     | (|len_wide[LENGTH_BITS+BYTE_BITS-1:LENGTH_BITS]);
   assign hdr_ok   = (magic_ff == magic_word_ff) && (len_next != '0) && !ovf_next
                     && (CSR_DATA_BITS'(len_next) <= max_length_ff);

   always_comb begin
      magic_word_in = magic_word_ff;
      max_length_in = max_length_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAGIC_WORD: magic_word_in = csr_wdata;
            CSR_MAX_LENGTH: max_length_in = csr_wdata;
            default: ;
         endcase
      end

      in_valid_in = (in_valid && in_ready) || (in_valid_ff && !advance);
      in_byte_in  = (in_valid && in_ready) ? in_byte : in_byte_ff;

      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      magic_in     = magic_ff;
      len_in       = len_ff;
      len_ovf_in   = len_ovf_ff;
      left_in      = left_ff;
      res          = '0;

      if (advance) begin
         case (phase_ff)
            PH_HEADER: begin
               if (!hdr_count_ff[2]) begin
                  magic_in[{hdr_count_ff[1:0], 3'b000} +: BYTE_BITS] = in_byte_ff;
               end else begin
                  len_in     = len_next;
                  len_ovf_in = ovf_next;
               end
               if (hdr_count_ff != HDR_LAST) begin
                  hdr_count_in = hdr_count_ff + 3'd1;
               end else begin
                  hdr_count_in = 3'd0;
                  if (hdr_ok) begin
                     left_in  = len_next;
                     phase_in = PH_PAYLOAD;
                  end else begin
                     phase_in             = PH_ERROR;
                     res.push             = 1'b1;
                     res.item.frame_error = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               left_in                = left_ff - LEN_ONE;
               res.push               = 1'b1;
               res.item.out_byte      = in_byte_ff;
               res.item.last_of_frame = (left_ff == LEN_ONE);
               if (left_ff == LEN_ONE) begin
                  phase_in = PH_HEADER;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      magic_ff   <= magic_in;
      len_ff     <= len_in;
      len_ovf_ff <= len_ovf_in;
      if (reset) begin
         magic_word_ff <= MAGIC_WORD_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_HEADER;
         hdr_count_ff  <= 3'd0;
         left_ff       <= '0;
      end else begin
         magic_word_ff <= magic_word_in;
         max_length_ff <= max_length_in;
         in_valid_ff   <= in_valid_in;
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         left_ff       <= left_in;
      end
   end

   a_no_rsp_in_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> !res.push)
      else $error("response pushed in error phase");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      res.push && res.item.frame_error |=> phase_ff == PH_ERROR)
      else $error("frame error did not enter error phase");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      res.push && res.item.last_of_frame |=> phase_ff == PH_HEADER && hdr_count_ff == 3'd0)
      else $error("last byte did not return to header phase");

endmodule

// File: hdl/mlfd_out_buf.sv
// Two-entry response buffer between the parser and the response channel.
module mlfd_out_buf
   import mlfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type res,
   output logic         res_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type entry_ff [2];
   rsp_item_type entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign res_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (res.push) begin
         entry_in[wr_ptr_ff] = res.item;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({res.push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !res.push)
      else $error("response pushed into full buffer");

endmodule
